/* hdl/temp_sensor_moving_average_macros.svh */
// Assertion helpers for the checker file of the temperature averager.
`ifndef TEMP_SENSOR_MOVING_AVERAGE_MACROS_SVH
`define TEMP_SENSOR_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define TSMA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define TSMA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/tsma_pkg.sv */
`timescale 1ns / 1ps
package tsma_pkg;

  localparam int unsigned NowW      = 32;
  localparam int unsigned AdcW      = 10;
  localparam int unsigned IntervalW = 16;
  localparam int unsigned RefW      = 13;
  localparam int unsigned OffsetW   = 10;
  localparam int unsigned TempW     = 16;
  localparam int unsigned ProdW     = AdcW + RefW;
  localparam int unsigned MvW       = 13;
  localparam int unsigned DivW      = 10;
  localparam int unsigned Q8Shift   = 9;
  localparam int unsigned CfgAddrW  = 8;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned WindowDefault = 16;

  localparam logic [IntervalW-1:0] IntervalReset = 16'd50;
  localparam logic [RefW-1:0]      RefReset      = 13'd2482;
  localparam logic [OffsetW-1:0]   OffsetReset   = 10'd400;

  // Constant divisors of the two conversion steps and the rounding bias of the second.
  localparam logic [DivW-1:0] AdcFullScale = 10'd1023;
  localparam logic [DivW-1:0] Q8Divisor    = 10'd39;
  localparam logic [ProdW-1:0] RoundBias   = 23'd19;

  // Magnitude limits for saturating to the signed 16-bit range.
  localparam logic [ProdW-1:0] TempMaxMag = 23'd32767;
  localparam logic [ProdW-1:0] TempMinMag = 23'd32768;
  localparam logic [TempW-1:0] TempMax    = 16'h7FFF;
  localparam logic [TempW-1:0] TempMin    = 16'h8000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_SAMPLE_INTERVAL = 8'd0,
    CFG_REF_MV          = 8'd1,
    CFG_OFFSET_MV       = 8'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [NowW-1:0] now_ms;
    logic [AdcW-1:0] adc_sample;
  } in_item_t;

  typedef struct packed {
    logic                    sampled;
    logic signed [TempW-1:0] avg_temp_q8;
    logic                    window_done;
  } out_item_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_item_t;

  typedef struct packed {
    logic signed [TempW-1:0] avg_temp_q8;
    logic                    window_done;
  } ring_status_t;

endpackage

/* hdl/tsma_stream_if.sv */
`timescale 1ns / 1ps
interface tsma_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/temp_sensor_moving_average.sv */
`timescale 1ns / 1ps
// Temperature averager: every input transaction carries a millisecond time and
// a raw 10-bit reading and yields exactly one result transaction. A reading is
// taken as a sample when the wrapped time since the last sample exceeds the
// sample interval; it is scaled to millivolts, converted to Q8 degrees Celsius
// and pushed into a WINDOW-entry ring whose running sum, shifted right by
// floor(log2 WINDOW), is the reported average. Items are handled one at a
// time. An item that is not sampled goes straight to the emit state, which
// loads its result into the output register once that register is free. A
// sampled item first goes through the bit-serial multiplier, then twice
// through the single bit-serial divider (millivolts, then Q8 degrees) and
// updates the ring. The next item is accepted as soon as the result is in
// the output register, even if that result is still waiting.
// Configuration writes are always accepted and take effect at once; the
// register index selects sample interval, reference millivolts or offset.
module temp_sensor_moving_average #(
  parameter int unsigned WINDOW = tsma_pkg::WindowDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tsma_stream_if.sink   in_i,
  tsma_stream_if.source out_o,
  tsma_stream_if.sink   cfg_i
);
  localparam int unsigned DiffW = tsma_pkg::MvW + 2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_DIV_MV = 5'b00100,
    ST_DIV_T  = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic                  in_valid, in_ready;
  tsma_pkg::in_item_t    in_item;
  logic                  out_valid, out_ready;
  tsma_pkg::out_item_t   out_item;
  logic                  cfg_valid, cfg_ready;
  tsma_pkg::cfg_item_t   cfg_item;

  logic [tsma_pkg::IntervalW-1:0] interval_q;
  logic [tsma_pkg::RefW-1:0]      ref_q;
  logic [tsma_pkg::OffsetW-1:0]   offset_q;
  logic [tsma_pkg::NowW-1:0]      last_q;
  logic                           samp_q, samp_d;
  logic                           neg_q, neg_d;
  logic                           out_valid_q, out_valid_d;
  tsma_pkg::out_item_t            out_data_q;

  logic                           in_accept;
  logic [tsma_pkg::NowW-1:0]      elapsed;
  logic                           take_sample;
  logic                           out_load;

  logic                           mul_start, mul_done;
  logic [tsma_pkg::ProdW-1:0]     product;
  logic                           div_start, div_done;
  logic [tsma_pkg::ProdW-1:0]     div_dividend, quotient;
  logic [tsma_pkg::DivW-1:0]      div_divisor;

  logic signed [DiffW-1:0]        mv_diff;
  logic [DiffW-1:0]               mv_abs;
  logic [tsma_pkg::ProdW-1:0]     scaled_mag;
  logic signed [tsma_pkg::TempW-1:0] temp_q8;
  logic                           ring_upd;
  tsma_pkg::ring_status_t         ring_status;

  assign in_valid     = in_i.valid;
  assign in_item      = in_i.data;
  assign in_i.ready   = in_ready;
  assign out_ready    = out_o.ready;
  assign out_o.valid  = out_valid;
  assign out_o.data   = out_item;
  assign cfg_valid    = cfg_i.valid;
  assign cfg_item     = cfg_i.data;
  assign cfg_i.ready  = cfg_ready;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_q == ST_IDLE);
  assign in_accept = in_valid && in_ready;

  // Wrapping difference; the interval compare is strict.
  assign elapsed     = in_item.now_ms - last_q;
  assign take_sample = elapsed > {{(tsma_pkg::NowW - tsma_pkg::IntervalW){1'b0}}, interval_q};

  // Millivolts minus offset, then |diff| * 512 + 19 for round-to-nearest by 39.
  assign mv_diff = {2'b00, quotient[tsma_pkg::MvW-1:0]}
                 - {{(DiffW - tsma_pkg::OffsetW){1'b0}}, offset_q};
  assign mv_abs  = mv_diff[DiffW-1] ? -mv_diff : mv_diff;
  assign scaled_mag = {{(tsma_pkg::ProdW - tsma_pkg::MvW - tsma_pkg::Q8Shift){1'b0}},
                       mv_abs[tsma_pkg::MvW-1:0], {tsma_pkg::Q8Shift{1'b0}}}
                    + tsma_pkg::RoundBias;

  // Apply the sign and saturate to the signed 16-bit range.
  always_comb begin
    if (neg_q) begin
      temp_q8 = (quotient > tsma_pkg::TempMinMag) ? tsma_pkg::TempMin
                                                  : -quotient[tsma_pkg::TempW-1:0];
    end else begin
      temp_q8 = (quotient > tsma_pkg::TempMaxMag) ? tsma_pkg::TempMax
                                                  : quotient[tsma_pkg::TempW-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    samp_d       = samp_q;
    neg_d        = neg_q;
    mul_start    = 1'b0;
    div_start    = 1'b0;
    div_dividend = product;
    div_divisor  = tsma_pkg::AdcFullScale;
    ring_upd     = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          samp_d    = take_sample;
          mul_start = take_sample;
          state_d   = take_sample ? ST_MUL : ST_EMIT;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          div_start = 1'b1;
          state_d   = ST_DIV_MV;
        end
      end
      ST_DIV_MV: begin
        if (div_done) begin
          div_start    = 1'b1;
          div_dividend = scaled_mag;
          div_divisor  = tsma_pkg::Q8Divisor;
          neg_d        = mv_diff[DiffW-1];
          state_d      = ST_DIV_T;
        end
      end
      ST_DIV_T: begin
        div_divisor = tsma_pkg::Q8Divisor;
        if (div_done) begin
          ring_upd = 1'b1;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      samp_q      <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= '0;
      interval_q  <= tsma_pkg::IntervalReset;
      ref_q       <= tsma_pkg::RefReset;
      offset_q    <= tsma_pkg::OffsetReset;
    end else begin
      state_q     <= state_d;
      samp_q      <= samp_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      if (in_accept && take_sample) begin
        last_q <= in_item.now_ms;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_item.addr)
          tsma_pkg::CFG_SAMPLE_INTERVAL: interval_q <= cfg_item.wdata[tsma_pkg::IntervalW-1:0];
          tsma_pkg::CFG_REF_MV:          ref_q      <= cfg_item.wdata[tsma_pkg::RefW-1:0];
          tsma_pkg::CFG_OFFSET_MV:       offset_q   <= cfg_item.wdata[tsma_pkg::OffsetW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q.sampled     <= samp_q;
      out_data_q.avg_temp_q8 <= ring_status.avg_temp_q8;
      out_data_q.window_done <= samp_q && ring_status.window_done;
    end
  end

  assign out_valid = out_valid_q;
  assign out_item  = out_data_q;

  tsma_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .adc_i     (in_item.adc_sample),
    .ref_i     (ref_q),
    .done_o    (mul_done),
    .product_o (product)
  );

  tsma_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  tsma_ring #(
    .WINDOW (WINDOW)
  ) u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (ring_upd),
    .temp_i   (temp_q8),
    .status_o (ring_status)
  );
endmodule

/* hdl/tsma_mul.sv */
`timescale 1ns / 1ps
// Shift-add multiplier: one multiplier bit per cycle, so only a RefW-bit adder.
module tsma_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [tsma_pkg::AdcW-1:0]    adc_i,
  input  logic [tsma_pkg::RefW-1:0]    ref_i,
  output logic                         done_o,
  output logic [tsma_pkg::ProdW-1:0]   product_o
);
  localparam int unsigned CntW = $clog2(tsma_pkg::AdcW);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [tsma_pkg::ProdW-1:0] p_q, p_d;
  logic [tsma_pkg::RefW:0]    hi_sum;

  // The upper part accumulates while the low part shifts out multiplier bits.
  always_comb begin
    hi_sum = {1'b0, p_q[tsma_pkg::ProdW-1:tsma_pkg::AdcW]};
    if (p_q[0]) begin
      hi_sum = hi_sum + {1'b0, ref_i};
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    p_d    = p_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      p_d    = {{tsma_pkg::RefW{1'b0}}, adc_i};
    end else if (busy_q) begin
      p_d   = {hi_sum, p_q[tsma_pkg::AdcW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(tsma_pkg::AdcW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign done_o    = done_q;
  assign product_o = p_q;
endmodule

/* hdl/tsma_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle. The remainder stays below the
// divisor, so it never needs more than DivW bits.
module tsma_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tsma_pkg::ProdW-1:0]  dividend_i,
  input  logic [tsma_pkg::DivW-1:0]   divisor_i,
  output logic                        done_o,
  output logic [tsma_pkg::ProdW-1:0]  quotient_o
);
  localparam int unsigned CntW = $clog2(tsma_pkg::ProdW);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [tsma_pkg::DivW-1:0]  rem_q, rem_d;
  logic [tsma_pkg::ProdW-1:0] quo_q, quo_d;
  logic [tsma_pkg::DivW:0]    trial;
  logic [tsma_pkg::DivW:0]    trial_sub;
  logic                       fits;

  assign trial     = {rem_q, quo_q[tsma_pkg::ProdW-1]};
  assign trial_sub = trial - {1'b0, divisor_i};
  assign fits      = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      rem_d = fits ? trial_sub[tsma_pkg::DivW-1:0] : trial[tsma_pkg::DivW-1:0];
      quo_d = {quo_q[tsma_pkg::ProdW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(tsma_pkg::ProdW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
endmodule

/* hdl/tsma_ring.sv */
`timescale 1ns / 1ps
// Sample ring with running sum. Entries that were never written read as zero
// through their valid bits.
module tsma_ring #(
  parameter int unsigned WINDOW = tsma_pkg::WindowDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               upd_i,
  input  logic signed [tsma_pkg::TempW-1:0]  temp_i,
  output tsma_pkg::ring_status_t             status_o
);
  localparam int unsigned PosW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CntW  = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = tsma_pkg::TempW + CntW;
  localparam int unsigned Shift = $clog2(WINDOW + 1) - 1;

  logic [tsma_pkg::TempW-1:0] mem [WINDOW];
  logic [tsma_pkg::TempW-1:0] rd_q;
  logic [WINDOW-1:0]          valid_q, valid_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic signed [SumW-1:0]     sum_q, sum_d;
  logic                       done_q, done_d;
  logic [tsma_pkg::TempW-1:0] old_entry;
  logic signed [SumW-1:0]     sum_shifted;

  // The read address only moves on an update, and updates are far apart, so
  // rd_q always holds the entry about to be replaced.
  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      mem[pos_q] <= temp_i;
    end
    rd_q <= mem[pos_q];
  end

  assign old_entry = valid_q[pos_q] ? rd_q : '0;

  always_comb begin
    valid_d = valid_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    done_d  = done_q;
    if (upd_i) begin
      valid_d[pos_q] = 1'b1;
      pos_d = (pos_q == PosW'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      sum_d = sum_q
            + {{(SumW - tsma_pkg::TempW){temp_i[tsma_pkg::TempW-1]}}, temp_i}
            - {{(SumW - tsma_pkg::TempW){old_entry[tsma_pkg::TempW-1]}}, old_entry};
      if (cnt_q < CntW'(WINDOW)) begin
        cnt_d  = cnt_q + 1'b1;
        done_d = 1'b0;
      end else begin
        cnt_d  = '0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      pos_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
      done_q  <= done_d;
    end
  end

  assign sum_shifted          = sum_q >>> Shift;
  assign status_o.avg_temp_q8 = sum_shifted[tsma_pkg::TempW-1:0];
  assign status_o.window_done = done_q;
endmodule

/* hdl/tsma_checker.sv */
`timescale 1ns / 1ps
`include "temp_sensor_moving_average_macros.svh"
module tsma_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_i,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input tsma_pkg::out_item_t out_item_i
);
  // Items are handled one at a time, so the input closes right after a
  // transaction.
  `TSMA_ASSERT_NEXT(a_in_closes, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i, "input still ready after a transaction")
  `TSMA_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_item_i), "stalled result changed")
  `TSMA_ASSERT_NOW(a_done_needs_sample, clk_i, rst_ni, out_valid_i && out_item_i.window_done, out_item_i.sampled, "window done on an item that was not sampled")
endmodule

bind temp_sensor_moving_average tsma_checker u_tsma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid),
  .in_ready_i  (in_ready),
  .out_valid_i (out_valid),
  .out_ready_i (out_ready),
  .out_item_i  (out_item)
);
